FILE: rtl/core/rma_pkg.sv
package rma_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
    localparam int WINDOW_DEF = 20;

    typedef enum logic
    {
        OP_SEED   = 1'b0,
        OP_FILTER = 1'b1
    } op_t;

endpackage

FILE: rtl/core/rma_ram.sv
module rma_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 20
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-first: a read of the address written in the same cycle returns the old word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/core/rma_div_const.sv
module rma_div_const import rma_pkg::*; #(
    parameter int DIVISOR = WINDOW_DEF,
    parameter int IN_W    = 17
) (
    input  logic [IN_W-1:0]     dividend,
    output logic [SAMPLE_W-1:0] quotient
);

    // reciprocal multiply, exact for every dividend below 2**IN_W
    localparam int SHIFT  = IN_W + $clog2(DIVISOR);
    localparam int MUL_W  = IN_W + 1;
    localparam int PROD_W = IN_W + MUL_W;
    localparam logic [MUL_W-1:0] RECIP =
        MUL_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic [PROD_W-1:0]       product;
    logic [PROD_W-SHIFT-1:0] q_full;

    assign product = PROD_W'(dividend) * PROD_W'(RECIP);
    assign q_full  = product[PROD_W-1:SHIFT];

    assign quotient = (q_full > (PROD_W - SHIFT)'(SAMPLE_MAX)) ? SAMPLE_W'(SAMPLE_MAX)
                                                              : q_full[SAMPLE_W-1:0];

endmodule

FILE: rtl/core/recursive_moving_average.sv
// channel   signals                        request content
// in        in_valid / in_ready            op (seed or filter), sample
// out       out_valid / out_ready          average
//
// one request per clock unless the output stalls: the state update and the divide by
// WINDOW sit between the ring read register and the average register, so throughput
// is one item per cycle. the result appears in the cycle after the request is taken.
// in_ready stays high while the average register is empty or being taken, so a stall
// on the output holds one result and blocks only the next request.
// reset clears sum, average, position and the ring's valid bits; no clearing pass.
module recursive_moving_average import rma_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                op,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SAMPLE_W-1:0] average
);

    localparam int POS_W = $clog2(WINDOW);
    localparam int SUM_W = $clog2(SAMPLE_MAX * WINDOW + 1);
    localparam int TOT_W = $clog2(SAMPLE_MAX * (WINDOW + 1) + 1);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);

    function automatic logic [POS_W-1:0] wrap_inc(input logic [POS_W-1:0] p);
        return (p == POS_LAST) ? '0 : p + 1'b1;
    endfunction

    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SAMPLE_W-1:0] last_avg_reg, last_avg_next;
    logic [SAMPLE_W-1:0] cur_entry_reg, cur_entry_next;   // ring entry at pos_reg
    logic [SAMPLE_W-1:0] seed_val_reg, seed_val_next;
    logic [WINDOW-1:0]   valid_reg, valid_next;
    logic                fwd_reg, fwd_next;
    logic [SAMPLE_W-1:0] fwd_data_reg, fwd_data_next;
    logic                out_valid_reg, out_valid_next;

    logic                accept;
    logic                is_filter;
    logic [POS_W-1:0]    pos_ahead;
    logic [POS_W-1:0]    rd_addr;
    logic                wr_en;
    logic [SAMPLE_W-1:0] ram_q;
    logic [SAMPLE_W-1:0] nxt_stored;
    logic [SAMPLE_W-1:0] nxt;
    logic [SUM_W-1:0]    sum_filt;
    logic [SUM_W-1:0]    sum_seed;
    logic [TOT_W-1:0]    total_raw;
    logic [TOT_W-1:0]    total;
    logic [SAMPLE_W-1:0] avg_filt;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign is_filter = (op_t'(op) == OP_FILTER);
    assign out_valid = out_valid_reg;
    assign average   = last_avg_reg;

    assign pos_ahead = wrap_inc(pos_reg);

    // entries not written since the last seed read as the seed value
    assign nxt_stored = fwd_reg ? fwd_data_reg : ram_q;
    assign nxt        = valid_reg[pos_ahead] ? nxt_stored : seed_val_reg;

    assign sum_filt  = sum_reg - SUM_W'(cur_entry_reg) + SUM_W'(last_avg_reg);
    assign sum_seed  = SUM_W'(SUM_W'(sample) * SUM_W'(WINDOW));
    assign total_raw = TOT_W'(sum_filt) + TOT_W'(sample);
    assign total     = (total_raw >= TOT_W'(nxt)) ? total_raw - TOT_W'(nxt) : '0;

    rma_div_const #(
        .DIVISOR (WINDOW),
        .IN_W    (TOT_W)
    ) u_div (
        .dividend (total),
        .quotient (avg_filt)
    );

    assign wr_en = accept && is_filter;

    always_comb
    begin
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        last_avg_next  = last_avg_reg;
        cur_entry_next = cur_entry_reg;
        seed_val_next  = seed_val_reg;
        valid_next     = valid_reg;
        if (accept)
        begin
            if (is_filter)
            begin
                pos_next            = pos_ahead;
                sum_next            = sum_filt;
                last_avg_next       = avg_filt;
                cur_entry_next      = nxt;
                valid_next[pos_reg] = 1'b1;
            end
            else
            begin
                pos_next       = '0;
                sum_next       = sum_seed;
                last_avg_next  = sample;
                cur_entry_next = sample;
                seed_val_next  = sample;
                valid_next     = '0;
            end
        end
    end

    // prefetch the entry after the next position
    assign rd_addr       = wrap_inc(pos_next);
    assign fwd_next      = wr_en && (pos_reg == rd_addr);
    assign fwd_data_next = last_avg_reg;

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    rma_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (pos_reg),
        .wr_data (last_avg_reg),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            sum_reg       <= '0;
            last_avg_reg  <= '0;
            cur_entry_reg <= '0;
            seed_val_reg  <= '0;
            valid_reg     <= '0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            last_avg_reg  <= last_avg_next;
            cur_entry_reg <= cur_entry_next;
            seed_val_reg  <= seed_val_next;
            valid_reg     <= valid_next;
            fwd_reg       <= fwd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= fwd_data_next;
    end

endmodule

FILE: rtl/core/rma_checker.sv
module rma_checker import rma_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                op,
    input logic [SAMPLE_W-1:0] sample,
    input logic                out_valid,
    input logic                out_ready,
    input logic [SAMPLE_W-1:0] average
);

    // a held result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(average))
        else $error("stalled average changed");

    // an empty output register never blocks a request
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("request blocked with empty output");

    // every taken request gives a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("taken request gave no result");

    // a seed returns its own sample
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (op_t'(op) == OP_SEED) |=> average == $past(sample))
        else $error("seed result differs from sample");

endmodule

bind recursive_moving_average rma_checker u_rma_checker (.*);
